[design/dsw_pkg.sv]
// Shared constants, command and status types for the dice sum ways counter.
package dsw_pkg;

  localparam int MAX_DICE   = 32;
  localparam int MAX_FACES  = 32;
  localparam int MAX_TARGET = 1024;

  localparam int DICE_W  = 6;
  localparam int FACE_W  = 6;
  localparam int SUM_W   = 11;
  localparam int WAYS_W  = 30;
  localparam int DEPTH   = MAX_TARGET + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;

  localparam logic [WAYS_W-1:0] PRIME_MOD = WAYS_W'(1000000007);

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new query
    logic start;     // begin the first row
    logic step;      // issue one row entry
    logic next_row;  // move on to the next row
    logic emit;      // place the result in the output register
  } dsw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trivial;   // result known without running rows
    logic t_last;    // issuing the final entry of the row
    logic row_last;  // current row is the final one
    logic out_free;  // output register can take a result
  } dsw_sts_t;

endpackage

[design/dsw_ram.sv]
// Row store: one write port, two registered read ports.
module dsw_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [dsw_pkg::ADDR_W-1:0]    waddr,
  input  logic [dsw_pkg::WAYS_W-1:0]    wdata,
  input  logic [dsw_pkg::ADDR_W-1:0]    ra_addr,
  input  logic [dsw_pkg::ADDR_W-1:0]    rb_addr,
  output logic [dsw_pkg::WAYS_W-1:0]    ra_data,
  output logic [dsw_pkg::WAYS_W-1:0]    rb_data
);
  import dsw_pkg::*;

  logic [WAYS_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two entries
  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[design/dsw_ctrl.sv]
// Controller state machine sequencing rows and entries of one query.
module dsw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output dsw_pkg::dsw_cmd_t cmd,
  input  dsw_pkg::dsw_sts_t sts
);
  import dsw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_ROW   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.trivial) begin
          state_nxt = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        cmd.step = 1'b1;
        if (sts.t_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.row_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.next_row = 1'b1;
          state_nxt    = S_ROW;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/dsw_dp.sv]
// Datapath: query registers, row counters, window sum, row stores, output register.
module dsw_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dsw_pkg::DICE_W-1:0]  dice_count,
  input  logic [dsw_pkg::FACE_W-1:0]  face_count,
  input  logic [dsw_pkg::SUM_W-1:0]   target_sum,
  input  dsw_pkg::dsw_cmd_t           cmd,
  output dsw_pkg::dsw_sts_t           sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [dsw_pkg::WAYS_W-1:0]  ways
);
  import dsw_pkg::*;

  logic [DICE_W-1:0] dice_r;
  logic [FACE_W-1:0] faces_r;
  logic [SUM_W-1:0]  target_r;
  logic [DICE_W-1:0] row_r;
  logic [SUM_W-1:0]  t_r;
  logic              sel_r;
  logic              v_r;
  logic [SUM_W-1:0]  tq_r;
  logic              sub_r;
  logic              bzero_r;
  logic              first_row_r;
  logic [WAYS_W-1:0] win_r;
  logic              out_valid_r;
  logic [WAYS_W-1:0] out_data_r;

  logic              trivial;
  logic              triv_one;
  logic [SUM_W-1:0]  ra_addr;
  logic [SUM_W-1:0]  rb_addr;
  logic [WAYS_W-1:0] m0_ra, m0_rb, m1_ra, m1_rb;
  logic [WAYS_W-1:0] rd_a, rd_b;
  logic [WAYS_W-1:0] add_v, sub_v, win_in, win_new;
  logic signed [WAYS_W+1:0] acc;

  // Queries that need no row pass
  assign trivial  = (dice_r == '0) || (target_r == '0) ||
                    (dice_r > DICE_W'(MAX_DICE)) || (target_r > SUM_W'(MAX_TARGET));
  assign triv_one = (dice_r == '0) && (target_r == '0);

  assign sts.trivial  = trivial;
  assign sts.t_last   = (t_r == target_r);
  assign sts.row_last = (row_r == dice_r);
  assign sts.out_free = !out_valid_r || out_tready;

  // Capture query, advance row and entry counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dice_r   <= dice_count;
      faces_r  <= (face_count > FACE_W'(MAX_FACES)) ? FACE_W'(MAX_FACES) : face_count;
      target_r <= target_sum;
    end
    if (cmd.start) begin
      row_r <= DICE_W'(1);
      t_r   <= SUM_W'(1);
      sel_r <= 1'b0;
    end else if (cmd.next_row) begin
      row_r <= row_r + DICE_W'(1);
      t_r   <= SUM_W'(1);
      sel_r <= ~sel_r;
    end else if (cmd.step) begin
      t_r <= t_r + SUM_W'(1);
    end
  end

  // Read addresses: entry t-1 enters the window, entry t-faces-1 leaves it
  assign ra_addr = t_r - SUM_W'(1);
  assign rb_addr = t_r - SUM_W'(faces_r) - SUM_W'(1);

  // Track the entry whose read data arrives next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    tq_r        <= t_r;
    sub_r       <= (t_r > SUM_W'(faces_r));
    bzero_r     <= (t_r == SUM_W'(faces_r) + SUM_W'(1));
    first_row_r <= (row_r == DICE_W'(1));
  end

  dsw_ram u_ram0 (
    .clk     (clk),
    .we      (v_r & sel_r),
    .waddr   (tq_r),
    .wdata   (win_new),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (m0_ra),
    .rb_data (m0_rb)
  );

  dsw_ram u_ram1 (
    .clk     (clk),
    .we      (v_r & ~sel_r),
    .waddr   (tq_r),
    .wdata   (win_new),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (m1_ra),
    .rb_data (m1_rb)
  );

  assign rd_a = sel_r ? m1_ra : m0_ra;
  assign rd_b = sel_r ? m1_rb : m0_rb;

  // Previous row: for the first row it is one at entry zero and zero elsewhere,
  // so skip the store; for later rows entry zero is zero
  always_comb begin
    if (first_row_r) begin
      add_v = (tq_r == SUM_W'(1)) ? WAYS_W'(1) : '0;
    end else if (tq_r == SUM_W'(1)) begin
      add_v = '0;
    end else begin
      add_v = rd_a;
    end
    if (!sub_r) begin
      sub_v = '0;
    end else if (first_row_r) begin
      sub_v = bzero_r ? WAYS_W'(1) : '0;
    end else if (bzero_r) begin
      sub_v = '0;
    end else begin
      sub_v = rd_b;
    end
  end

  // Slide the window: add the entering entry, drop the leaving one, reduce
  assign win_in = (tq_r == SUM_W'(1)) ? '0 : win_r;
  assign acc    = $signed({2'b00, win_in}) + $signed({2'b00, add_v}) -
                  $signed({2'b00, sub_v});

  always_comb begin
    if (acc[WAYS_W+1]) begin
      win_new = WAYS_W'(acc + $signed({2'b00, PRIME_MOD}));
    end else if (acc >= $signed({2'b00, PRIME_MOD})) begin
      win_new = WAYS_W'(acc - $signed({2'b00, PRIME_MOD}));
    end else begin
      win_new = acc[WAYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v_r) begin
      win_r <= win_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= trivial ? (triv_one ? WAYS_W'(1) : '0) : win_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign ways       = out_data_r;

endmodule

[design/dice_sum_ways_counter.sv]
// Each query runs one row per die: row entries pass through the window adder at one per cycle,
// and each row ends in a drain state before the next row starts.
// Throughput: one query at a time; the next is taken once the result is in the
// output register, which holds it while the next query runs.
// Out-of-range and zero-dice or zero-target queries skip the row pass and go straight to the output register.
// Reset (rst_n low, synchronous) clears the controller and valid flags; no row clearing pass.
module dice_sum_ways_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [5:0] dice_count, [11:6] face_count, [22:12] target_sum
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] ways
);
  import dsw_pkg::*;

  dsw_cmd_t          cmd;
  dsw_sts_t          sts;
  logic [WAYS_W-1:0] ways;

  dsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dsw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dice_count (in_tdata[5:0]),
    .face_count (in_tdata[11:6]),
    .target_sum (in_tdata[22:12]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ways       (ways)
  );

  assign out_tdata = {{(OUT_W-WAYS_W){1'b0}}, ways};

endmodule

[dv/tb_dice_sum_ways_counter.sv]
// Self-checking testbench for the dice sum ways counter stream block.
module tb_dice_sum_ways_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import dsw_pkg::*;

  // One query in flight together with the ways count it should produce
  typedef struct {
    logic [DICE_W-1:0] dice;
    logic [FACE_W-1:0] faces;
    logic [SUM_W-1:0]  target;
    logic [WAYS_W-1:0] ways;
  } ways_entry_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [5:0] dice_count, [11:6] face_count, [22:12] target_sum
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [29:0] ways

  ways_entry_t pending_ways[$];
  int          error_count = 0;
  bit          no_gaps = 1'b0;

  dice_sum_ways_counter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Modular add of two values already below the prime
  function automatic logic [31:0] add_mod_prime(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (s >= 32'(PRIME_MOD)) s = s - 32'(PRIME_MOD);
    return s;
  endfunction

  // Count ordered rolls reaching the target, row by row with a sliding window
  function automatic logic [WAYS_W-1:0] count_ways(input logic [DICE_W-1:0] dice,
                                                   input logic [FACE_W-1:0] faces,
                                                   input logic [SUM_W-1:0]  target);
    logic [31:0] prev_row [0:MAX_TARGET];
    logic [31:0] cur_row  [0:MAX_TARGET];
    logic [31:0] window;
    int          eff_faces;
    if (dice > MAX_DICE || target > MAX_TARGET) return '0;
    eff_faces = (faces > MAX_FACES) ? MAX_FACES : int'(faces);
    foreach (prev_row[i]) begin
      prev_row[i] = '0;
      cur_row[i]  = '0;
    end
    prev_row[0] = 32'd1;
    for (int row = 1; row <= dice; row++) begin
      window     = '0;
      cur_row[0] = '0;
      for (int t = 1; t <= target; t++) begin
        window = add_mod_prime(window, prev_row[t-1]);
        if (t >= eff_faces + 1)
          window = add_mod_prime(window, 32'(PRIME_MOD) - prev_row[t-eff_faces-1]);
        cur_row[t] = window;
      end
      for (int t = 0; t <= target; t++) prev_row[t] = cur_row[t];
    end
    return prev_row[target][WAYS_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Drive one query after a random gap and record its expected result on acceptance
  task automatic send_query(input logic [DICE_W-1:0] dice, input logic [FACE_W-1:0] faces,
                            input logic [SUM_W-1:0] target);
    int          idle;
    ways_entry_t entry;
    idle = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, target, faces, dice};
    do @(posedge clk); while (!in_tready);
    entry.dice   = dice;
    entry.faces  = faces;
    entry.target = target;
    entry.ways   = count_ways(dice, faces, target);
    pending_ways.push_back(entry);
  endtask

  // Result side: random stall before each transaction
  initial begin : result_ready
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    ways_entry_t entry;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ways.size() == 0) begin
        report_mismatch($sformatf("unexpected result ways %0d", out_tdata[WAYS_W-1:0]));
      end else begin
        entry = pending_ways.pop_front();
        if (out_tdata[WAYS_W-1:0] !== entry.ways)
          report_mismatch($sformatf("dice %0d faces %0d target %0d: ways %0d, expected %0d",
                                    entry.dice, entry.faces, entry.target,
                                    out_tdata[WAYS_W-1:0], entry.ways));
      end
    end
  end

  // No dice: one way only for a zero target
  task automatic test_no_dice();
    send_query(6'd0, 6'd6, 11'd0);
    send_query(6'd0, 6'd6, 11'd5);
    send_query(6'd0, 6'd0, 11'd0);
    send_query(6'd0, 6'd32, 11'd1024);
  endtask

  // Zero target with dice present never matches
  task automatic test_zero_target();
    send_query(6'd3, 6'd6, 11'd0);
    send_query(6'd32, 6'd32, 11'd0);
  endtask

  // Zero faces leaves no roll at all
  task automatic test_zero_faces();
    send_query(6'd2, 6'd0, 11'd2);
    send_query(6'd1, 6'd0, 11'd0);
    send_query(6'd5, 6'd0, 11'd17);
  endtask

  // Face counts above the maximum saturate; single-face dice
  task automatic test_face_limits();
    send_query(6'd2, 6'd63, 11'd40);
    send_query(6'd3, 6'd33, 11'd50);
    send_query(6'd2, 6'd32, 11'd64);
    send_query(6'd1, 6'd1, 11'd1);
    send_query(6'd32, 6'd1, 11'd32);
  endtask

  // Dice or target past the limits give zero
  task automatic test_out_of_range();
    send_query(6'd33, 6'd6, 11'd10);
    send_query(6'd63, 6'd63, 11'd2047);
    send_query(6'd4, 6'd6, 11'd1025);
    send_query(6'd1, 6'd21, 11'd1536);
  endtask

  // Largest sizes the block handles, plus smaller single-die and seven-dice queries
  task automatic test_extremes();
    send_query(6'd32, 6'd32, 11'd1024);
    send_query(6'd32, 6'd31, 11'd1023);
    send_query(6'd1, 6'd32, 11'd32);
    send_query(6'd7, 6'd6, 11'd24);
  endtask

  // Back-to-back small queries with both sides always ready
  task automatic test_steady_stream();
    no_gaps = 1'b1;
    for (int n = 0; n < 15; n++)
      send_query(6'($urandom_range(0, 5)), 6'($urandom_range(1, 8)), 11'($urandom_range(0, 30)));
    no_gaps = 1'b0;
  endtask

  // Mostly small queries, some medium, a few near full size and some out of range
  task automatic test_random_queries();
    logic [DICE_W-1:0] dice;
    logic [FACE_W-1:0] faces;
    logic [SUM_W-1:0]  target;
    for (int n = 0; n < 63; n++) begin
      faces = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(1, 12));
      if (n % 20 == 19) begin
        dice   = 6'($urandom_range(24, 32));
        target = 11'($urandom_range(700, 1024));
      end else if (n % 10 == 7) begin
        if ($urandom_range(0, 1) == 0) begin
          dice   = 6'($urandom_range(33, 63));
          target = 11'($urandom_range(0, 2047));
        end else begin
          dice   = 6'($urandom_range(0, 63));
          target = 11'($urandom_range(1025, 2047));
        end
      end else if (n % 5 == 2) begin
        dice   = 6'($urandom_range(0, 32));
        target = 11'($urandom_range(0, 160));
      end else begin
        dice   = 6'($urandom_range(0, 6));
        target = 11'($urandom_range(0, 48));
      end
      send_query(dice, faces, target);
    end
  endtask

  // Hold reset, run every test, then drain and decide
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_no_dice();
    test_zero_target();
    test_zero_faces();
    test_face_limits();
    test_out_of_range();
    test_extremes();
    test_steady_stream();
    test_random_queries();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ways.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_ways.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_ways.size()));

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
